### rtl/kf1d_pkg.sv
// ----------------------------------------------------------------------------
// kf1d_pkg
// shared constants, micro-op codes and control types for the 1-d kalman filter
// ----------------------------------------------------------------------------
package kf1d_pkg;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int INIT_VARIANCE_DEF = 1000;

    localparam int ADDR_WIDTH = 5;

    // register indexes
    localparam logic [2:0] REG_TIME_STEP  = 3'd0;
    localparam logic [2:0] REG_MEAS_NOISE = 3'd1;
    localparam logic [2:0] REG_Q_POS      = 3'd2;
    localparam logic [2:0] REG_Q_CROSS    = 3'd3;
    localparam logic [2:0] REG_Q_VEL      = 3'd4;

    // micro-op codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_ZGAIN = 3'd4;

    // operand and destination selects
    localparam logic [4:0] SEL_POS = 5'd0;
    localparam logic [4:0] SEL_VEL = 5'd1;
    localparam logic [4:0] SEL_P00 = 5'd2;
    localparam logic [4:0] SEL_P01 = 5'd3;
    localparam logic [4:0] SEL_P11 = 5'd4;
    localparam logic [4:0] SEL_S   = 5'd5;
    localparam logic [4:0] SEL_K0  = 5'd6;
    localparam logic [4:0] SEL_K1  = 5'd7;
    localparam logic [4:0] SEL_Y   = 5'd8;
    localparam logic [4:0] SEL_N00 = 5'd9;
    localparam logic [4:0] SEL_N01 = 5'd10;
    localparam logic [4:0] SEL_N11 = 5'd11;
    localparam logic [4:0] SEL_A   = 5'd12;
    localparam logic [4:0] SEL_T   = 5'd13;
    localparam logic [4:0] SEL_Z   = 5'd14;
    localparam logic [4:0] SEL_DT  = 5'd15;
    localparam logic [4:0] SEL_R   = 5'd16;
    localparam logic [4:0] SEL_QP  = 5'd17;
    localparam logic [4:0] SEL_QC  = 5'd18;
    localparam logic [4:0] SEL_QV  = 5'd19;

    localparam logic [4:0] PC_DIV_K0 = 5'd1;
    localparam logic [4:0] PC_Y      = 5'd3;
    localparam logic [4:0] PC_LAST   = 5'd24;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic       var_clamp;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   issue;
        logic   emit;
        ucode_t uc;
    } cmd_t;

    typedef struct packed {
        logic s_zero;
        logic div_done;
    } sts_t;

    // update then predict, one operation per entry
    function automatic ucode_t ucode(input logic [4:0] pc);
        ucode_t u;
        unique case (pc)
            5'd0:    u = '{OP_ADD, SEL_P00, SEL_R,   SEL_S,   1'b0};
            5'd1:    u = '{OP_DIV, SEL_P00, SEL_S,   SEL_K0,  1'b0};
            5'd2:    u = '{OP_DIV, SEL_P01, SEL_S,   SEL_K1,  1'b0};
            5'd3:    u = '{OP_SUB, SEL_Z,   SEL_POS, SEL_Y,   1'b0};
            5'd4:    u = '{OP_MUL, SEL_K0,  SEL_Y,   SEL_T,   1'b0};
            5'd5:    u = '{OP_ADD, SEL_POS, SEL_T,   SEL_POS, 1'b0};
            5'd6:    u = '{OP_MUL, SEL_K1,  SEL_Y,   SEL_T,   1'b0};
            5'd7:    u = '{OP_ADD, SEL_VEL, SEL_T,   SEL_VEL, 1'b0};
            5'd8:    u = '{OP_MUL, SEL_K0,  SEL_P00, SEL_T,   1'b0};
            5'd9:    u = '{OP_SUB, SEL_P00, SEL_T,   SEL_N00, 1'b1};
            5'd10:   u = '{OP_MUL, SEL_K0,  SEL_P01, SEL_T,   1'b0};
            5'd11:   u = '{OP_SUB, SEL_P01, SEL_T,   SEL_N01, 1'b0};
            5'd12:   u = '{OP_MUL, SEL_K1,  SEL_P01, SEL_T,   1'b0};
            5'd13:   u = '{OP_SUB, SEL_P11, SEL_T,   SEL_N11, 1'b1};
            5'd14:   u = '{OP_MUL, SEL_DT,  SEL_VEL, SEL_T,   1'b0};
            5'd15:   u = '{OP_ADD, SEL_POS, SEL_T,   SEL_POS, 1'b0};
            5'd16:   u = '{OP_MUL, SEL_DT,  SEL_N11, SEL_T,   1'b0};
            5'd17:   u = '{OP_ADD, SEL_N01, SEL_T,   SEL_A,   1'b0};
            5'd18:   u = '{OP_MUL, SEL_DT,  SEL_N01, SEL_T,   1'b0};
            5'd19:   u = '{OP_ADD, SEL_N00, SEL_T,   SEL_N00, 1'b0};
            5'd20:   u = '{OP_MUL, SEL_DT,  SEL_A,   SEL_T,   1'b0};
            5'd21:   u = '{OP_ADD, SEL_N00, SEL_T,   SEL_N00, 1'b0};
            5'd22:   u = '{OP_ADD, SEL_N00, SEL_QP,  SEL_P00, 1'b1};
            5'd23:   u = '{OP_ADD, SEL_A,   SEL_QC,  SEL_P01, 1'b0};
            5'd24:   u = '{OP_ADD, SEL_N11, SEL_QV,  SEL_P11, 1'b1};
            default: u = '{OP_ADD, SEL_T,   SEL_T,   SEL_T,   1'b0};
        endcase
        return u;
    endfunction

endpackage

### rtl/kf1d_if.sv
// ----------------------------------------------------------------------------
// kf1d_if
// request channels: measurement in, estimate out
// ----------------------------------------------------------------------------
interface kf1d_meas_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface kf1d_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_est;
    logic signed [31:0] vel_est;
    logic        [30:0] var_pos;
    logic signed [31:0] cov_cross;
    logic        [30:0] var_vel;
    logic               sat_flag;

    modport source (output valid, output pos_est, output vel_est, output var_pos,
                    output cov_cross, output var_vel, output sat_flag, input ready);
    modport sink   (input valid, input pos_est, input vel_est, input var_pos,
                    input cov_cross, input var_vel, input sat_flag, output ready);
endinterface

### rtl/kalman_filter_1d_const_velocity.sv
// ----------------------------------------------------------------------------
// kalman_filter_1d_const_velocity
// two-state constant-velocity kalman filter, saturating fixed point
// ----------------------------------------------------------------------------
// a zero innovation variance skips both divisions; a new measurement is accepted only
//   in idle, after the previous estimate is emitted, so the two bit-serial divisions
//   set the request rate, and a result still waiting at est adds stalls
// reset: state to zero position/velocity and INIT_VARIANCE variances,
//   registers to dt = 1.0, R = 1.0, process noise 0; no clearing pass
module kalman_filter_1d_const_velocity #(
    parameter int DATA_WIDTH    = kf1d_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = kf1d_pkg::FRAC_BITS_DEF,
    parameter int INIT_VARIANCE = kf1d_pkg::INIT_VARIANCE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kf1d_meas_if.sink                       meas,
    kf1d_est_if.source                      est,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kf1d_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // configuration registers
    logic [30:0] time_step_reg;
    logic [30:0] meas_noise_reg;
    logic [30:0] q_pos_reg;
    logic [31:0] q_cross_reg;
    logic [30:0] q_vel_reg;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= 31'(1) << FRAC_BITS;
            meas_noise_reg <= 31'(1) << FRAC_BITS;
            q_pos_reg      <= '0;
            q_cross_reg    <= '0;
            q_vel_reg      <= '0;
        end
        else if (wr_en)
        begin
            // writes beyond the register list are dropped
            unique case (reg_idx)
                kf1d_pkg::REG_TIME_STEP:  time_step_reg  <= pwdata[30:0];
                kf1d_pkg::REG_MEAS_NOISE: meas_noise_reg <= pwdata[30:0];
                kf1d_pkg::REG_Q_POS:      q_pos_reg      <= pwdata[30:0];
                kf1d_pkg::REG_Q_CROSS:    q_cross_reg    <= pwdata;
                kf1d_pkg::REG_Q_VEL:      q_vel_reg      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            kf1d_pkg::REG_TIME_STEP:  prdata = {1'b0, time_step_reg};
            kf1d_pkg::REG_MEAS_NOISE: prdata = {1'b0, meas_noise_reg};
            kf1d_pkg::REG_Q_POS:      prdata = {1'b0, q_pos_reg};
            kf1d_pkg::REG_Q_CROSS:    prdata = q_cross_reg;
            kf1d_pkg::REG_Q_VEL:      prdata = {1'b0, q_vel_reg};
            default:                  prdata = '0;
        endcase
    end

    // controller and datapath talk only through cmd and sts
    kf1d_pkg::cmd_t cmd;
    kf1d_pkg::sts_t sts;

    kf1d_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas.valid),
        .meas_ready (meas.ready),
        .est_valid  (est.valid),
        .est_ready  (est.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    kf1d_dp #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRAC_BITS     (FRAC_BITS),
        .INIT_VARIANCE (INIT_VARIANCE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .measurement (meas.measurement),
        .time_step   (time_step_reg),
        .meas_noise  (meas_noise_reg),
        .q_pos       (q_pos_reg),
        .q_cross     (q_cross_reg),
        .q_vel       (q_vel_reg),
        .pos_est     (est.pos_est),
        .vel_est     (est.vel_est),
        .var_pos     (est.var_pos),
        .cov_cross   (est.cov_cross),
        .var_vel     (est.var_vel),
        .sat_flag    (est.sat_flag)
    );

endmodule

### rtl/kf1d_ctrl.sv
// ----------------------------------------------------------------------------
// kf1d_ctrl
// sequencer stepping the micro-program through the datapath
// ----------------------------------------------------------------------------
module kf1d_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              meas_valid,
    output logic              meas_ready,
    output logic              est_valid,
    input  logic              est_ready,
    output kf1d_pkg::cmd_t    cmd,
    input  kf1d_pkg::sts_t    sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    logic       out_valid_reg, out_valid_next;

    assign meas_ready = (state_reg == ST_IDLE);
    assign est_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !est_ready;
        cmd.load       = 1'b0;
        cmd.issue      = 1'b0;
        cmd.emit       = 1'b0;
        cmd.uc         = kf1d_pkg::ucode(pc_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    cmd.load   = 1'b1;
                    pc_next    = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (pc_reg == kf1d_pkg::PC_DIV_K0 && sts.s_zero)
                begin
                    // zero innovation variance: skip both divisions
                    cmd.uc.op = kf1d_pkg::OP_ZGAIN;
                    pc_next   = kf1d_pkg::PC_Y;
                end
                else if (cmd.uc.op == kf1d_pkg::OP_DIV)
                begin
                    state_next = ST_WAIT;
                end
                else if (pc_reg == kf1d_pkg::PC_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pc_next = pc_reg + 5'd1;
                end
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    pc_next    = pc_reg + 5'd1;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || est_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/kf1d_dp.sv
// ----------------------------------------------------------------------------
// kf1d_dp
// filter state, saturating alu, multiplier and bit-serial divider
// ----------------------------------------------------------------------------
module kf1d_dp #(
    parameter int DATA_WIDTH    = kf1d_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS     = kf1d_pkg::FRAC_BITS_DEF,
    parameter int INIT_VARIANCE = kf1d_pkg::INIT_VARIANCE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kf1d_pkg::cmd_t     cmd,
    output kf1d_pkg::sts_t     sts,
    input  logic signed [31:0] measurement,
    input  logic        [30:0] time_step,
    input  logic        [30:0] meas_noise,
    input  logic        [30:0] q_pos,
    input  logic signed [31:0] q_cross,
    input  logic        [30:0] q_vel,
    output logic signed [31:0] pos_est,
    output logic signed [31:0] vel_est,
    output logic        [30:0] var_pos,
    output logic signed [31:0] cov_cross,
    output logic        [30:0] var_vel,
    output logic               sat_flag
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int FW = 2 * W + F + 1;
    localparam int NB = W + F;
    localparam int CW = $clog2(NB);

    typedef logic signed [W-1:0] val_t;

    function automatic logic [W:0] clampw(input logic signed [64:0] v);
        logic signed [64:0] maxv;
        logic signed [64:0] minv;
        maxv = (65'sd1 <<< (W - 1)) - 65'sd1;
        minv = -maxv - 65'sd1;
        if (v > maxv)
            return {1'b1, maxv[W-1:0]};
        else if (v < minv)
            return {1'b1, minv[W-1:0]};
        else
            return {1'b0, v[W-1:0]};
    endfunction

    // signed result from magnitude and sign, saturating
    function automatic logic [W:0] fixw(input logic neg, input logic [FW-1:0] q);
        logic [FW-1:0] lim;
        logic [W-1:0]  qt;
        lim = FW'(1) << (W - 1);
        qt  = q[W-1:0];
        if (neg)
        begin
            if (q > lim)
                return {1'b1, 1'b1, {(W-1){1'b0}}};
            else
                return {1'b0, W'(-qt)};
        end
        else
        begin
            if (q >= lim)
                return {1'b1, 1'b0, {(W-1){1'b1}}};
            else
                return {1'b0, qt};
        end
    endfunction

    function automatic logic [W-1:0] magw(input val_t v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    localparam logic [W:0] IV_W = clampw(65'(INIT_VARIANCE) <<< F);

    val_t pos_reg, vel_reg, p00_reg, p01_reg, p11_reg;
    val_t s_reg, k0_reg, k1_reg, y_reg, n00_reg, n01_reg, n11_reg, a_reg, t_reg, z_reg;
    logic flag_reg;

    // clamped inputs and registers
    logic [W:0] z_c, dt_c, r_c, qp_c, qc_c, qv_c;
    assign z_c  = clampw(65'(measurement));
    assign dt_c = clampw(65'($signed({1'b0, time_step})));
    assign r_c  = clampw(65'($signed({1'b0, meas_noise})));
    assign qp_c = clampw(65'($signed({1'b0, q_pos})));
    assign qc_c = clampw(65'(q_cross));
    assign qv_c = clampw(65'($signed({1'b0, q_vel})));

    function automatic val_t pick(
        input logic [4:0] sel,
        input val_t pos, input val_t vel, input val_t p00, input val_t p01,
        input val_t p11, input val_t s, input val_t k0, input val_t k1,
        input val_t y, input val_t n00, input val_t n01, input val_t n11,
        input val_t a, input val_t t, input val_t z, input val_t dt,
        input val_t r, input val_t qp, input val_t qc, input val_t qv);
        val_t v;
        unique case (sel)
            kf1d_pkg::SEL_POS: v = pos;
            kf1d_pkg::SEL_VEL: v = vel;
            kf1d_pkg::SEL_P00: v = p00;
            kf1d_pkg::SEL_P01: v = p01;
            kf1d_pkg::SEL_P11: v = p11;
            kf1d_pkg::SEL_S:   v = s;
            kf1d_pkg::SEL_K0:  v = k0;
            kf1d_pkg::SEL_K1:  v = k1;
            kf1d_pkg::SEL_Y:   v = y;
            kf1d_pkg::SEL_N00: v = n00;
            kf1d_pkg::SEL_N01: v = n01;
            kf1d_pkg::SEL_N11: v = n11;
            kf1d_pkg::SEL_A:   v = a;
            kf1d_pkg::SEL_T:   v = t;
            kf1d_pkg::SEL_Z:   v = z;
            kf1d_pkg::SEL_DT:  v = dt;
            kf1d_pkg::SEL_R:   v = r;
            kf1d_pkg::SEL_QP:  v = qp;
            kf1d_pkg::SEL_QC:  v = qc;
            kf1d_pkg::SEL_QV:  v = qv;
            default:           v = '0;
        endcase
        return v;
    endfunction

    val_t opa, opb;
    assign opa = pick(cmd.uc.src_a, pos_reg, vel_reg, p00_reg, p01_reg, p11_reg, s_reg,
                      k0_reg, k1_reg, y_reg, n00_reg, n01_reg, n11_reg, a_reg, t_reg,
                      z_reg, dt_c[W-1:0], r_c[W-1:0], qp_c[W-1:0], qc_c[W-1:0],
                      qv_c[W-1:0]);
    assign opb = pick(cmd.uc.src_b, pos_reg, vel_reg, p00_reg, p01_reg, p11_reg, s_reg,
                      k0_reg, k1_reg, y_reg, n00_reg, n01_reg, n11_reg, a_reg, t_reg,
                      z_reg, dt_c[W-1:0], r_c[W-1:0], qp_c[W-1:0], qc_c[W-1:0],
                      qv_c[W-1:0]);

    // alu
    logic signed [W:0] sum_w, dif_w;
    logic [W-1:0]      ma, mb;
    logic [2*W-1:0]    prod;
    logic [2*W:0]      prod_r;
    logic [W:0]        alu_res;

    assign sum_w  = (W+1)'(opa) + (W+1)'(opb);
    assign dif_w  = (W+1)'(opa) - (W+1)'(opb);
    assign ma     = magw(opa);
    assign mb     = magw(opb);
    assign prod   = (2*W)'(ma) * (2*W)'(mb);
    assign prod_r = (2*W+1)'(prod) + ((2*W+1)'(1) << (F - 1));

    always_comb
    begin
        unique case (cmd.uc.op)
            kf1d_pkg::OP_ADD: alu_res = clampw(65'(sum_w));
            kf1d_pkg::OP_SUB: alu_res = clampw(65'(dif_w));
            kf1d_pkg::OP_MUL: alu_res = fixw(opa[W-1] != opb[W-1], FW'(prod_r >> F));
            default:          alu_res = '0;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    logic          div_busy_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [W:0]    div_rem_reg;
    logic [NB-1:0] div_num_reg;
    logic [NB-1:0] div_quo_reg;
    logic [W-1:0]  div_dm_reg;
    logic          div_neg_reg;
    logic [4:0]    div_dst_reg;

    logic [W:0]    rem_sh, rem_nx;
    logic          qbit;
    logic [NB-1:0] quo_nx;
    logic [W+1:0]  rem_dbl;
    logic [FW-1:0] quo_rnd;
    logic [W:0]    div_res;
    logic          div_last;

    assign rem_sh   = {div_rem_reg[W-1:0], div_num_reg[NB-1]};
    assign qbit     = (rem_sh >= (W+1)'(div_dm_reg));
    assign rem_nx   = qbit ? rem_sh - (W+1)'(div_dm_reg) : rem_sh;
    assign quo_nx   = {div_quo_reg[NB-2:0], qbit};
    assign rem_dbl  = {rem_nx, 1'b0};
    assign quo_rnd  = FW'(quo_nx) + FW'(rem_dbl >= (W+2)'(div_dm_reg));
    assign div_res  = fixw(div_neg_reg, quo_rnd);
    assign div_last = div_busy_reg && (div_cnt_reg == '0);

    assign sts.div_done = div_last;
    assign sts.s_zero   = (s_reg == '0);

    // write-back
    logic       wb_en;
    logic [4:0] wb_dst;
    logic [W:0] wb_res;
    val_t       wb_val;
    logic       wb_flag;

    always_comb
    begin
        wb_en  = 1'b0;
        wb_dst = cmd.uc.dst;
        wb_res = alu_res;
        if (div_last)
        begin
            wb_en  = 1'b1;
            wb_dst = div_dst_reg;
            wb_res = div_res;
        end
        else if (cmd.issue && cmd.uc.op != kf1d_pkg::OP_DIV
                 && cmd.uc.op != kf1d_pkg::OP_ZGAIN)
        begin
            wb_en = 1'b1;
        end
        wb_val  = wb_res[W-1:0];
        wb_flag = wb_res[W];
        // variance never negative
        if (cmd.uc.var_clamp && !div_last && wb_val[W-1])
        begin
            wb_val  = '0;
            wb_flag = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            vel_reg      <= '0;
            p00_reg      <= IV_W[W-1:0];
            p01_reg      <= '0;
            p11_reg      <= IV_W[W-1:0];
            flag_reg     <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                flag_reg <= z_c[W] | dt_c[W] | r_c[W] | qp_c[W] | qc_c[W] | qv_c[W];
            end
            else if (cmd.issue && cmd.uc.op == kf1d_pkg::OP_ZGAIN)
            begin
                flag_reg <= 1'b1;
            end
            else if (wb_en && wb_flag)
            begin
                flag_reg <= 1'b1;
            end

            if (wb_en)
            begin
                unique case (wb_dst)
                    kf1d_pkg::SEL_POS: pos_reg <= wb_val;
                    kf1d_pkg::SEL_VEL: vel_reg <= wb_val;
                    kf1d_pkg::SEL_P00: p00_reg <= wb_val;
                    kf1d_pkg::SEL_P01: p01_reg <= wb_val;
                    kf1d_pkg::SEL_P11: p11_reg <= wb_val;
                    default: ;
                endcase
            end

            if (cmd.issue && cmd.uc.op == kf1d_pkg::OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= CW'(NB - 1);
            end
            else if (div_last)
            begin
                div_busy_reg <= 1'b0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - CW'(1);
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg <= z_c[W-1:0];
        end
        if (cmd.issue && cmd.uc.op == kf1d_pkg::OP_ZGAIN)
        begin
            k0_reg <= '0;
            k1_reg <= '0;
        end
        if (wb_en)
        begin
            unique case (wb_dst)
                kf1d_pkg::SEL_S:   s_reg   <= wb_val;
                kf1d_pkg::SEL_K0:  k0_reg  <= wb_val;
                kf1d_pkg::SEL_K1:  k1_reg  <= wb_val;
                kf1d_pkg::SEL_Y:   y_reg   <= wb_val;
                kf1d_pkg::SEL_N00: n00_reg <= wb_val;
                kf1d_pkg::SEL_N01: n01_reg <= wb_val;
                kf1d_pkg::SEL_N11: n11_reg <= wb_val;
                kf1d_pkg::SEL_A:   a_reg   <= wb_val;
                kf1d_pkg::SEL_T:   t_reg   <= wb_val;
                default: ;
            endcase
        end
        if (cmd.issue && cmd.uc.op == kf1d_pkg::OP_DIV)
        begin
            div_rem_reg <= '0;
            div_num_reg <= {ma, {F{1'b0}}};
            div_quo_reg <= '0;
            div_dm_reg  <= mb;
            div_neg_reg <= (opa[W-1] != opb[W-1]);
            div_dst_reg <= cmd.uc.dst;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= rem_nx;
            div_num_reg <= {div_num_reg[NB-2:0], 1'b0};
            div_quo_reg <= quo_nx;
        end
        if (cmd.emit)
        begin
            pos_est   <= 32'(pos_reg);
            vel_est   <= 32'(vel_reg);
            var_pos   <= 31'(p00_reg);
            cov_cross <= 32'(p01_reg);
            var_vel   <= 31'(p11_reg);
            sat_flag  <= flag_reg;
        end
    end

endmodule
